### hdl/csm_pkg.sv
package csm_pkg;

  localparam int MAX_PEOPLE  = 64;
  localparam int MAX_QUOTA   = 32;
  localparam int IW          = 6;                  // person / partner index width
  localparam int PAW         = 2 * IW;             // pair address width
  localparam int QSW         = 5;                  // holder slot index width
  localparam int HAW         = IW + QSW;           // holder slot address width
  localparam int QAW         = IW + 1;             // waiting queue address width
  localparam int QUEUE_DEPTH = 2 * MAX_PEOPLE;
  localparam int RKW         = IW + 1;             // rank, absent proposer ranks n
  localparam int CNTW        = PAW + 1;

  localparam logic [5:0] QUOTA_RST  = 6'd20;
  localparam logic [6:0] ACTIVE_RST = 7'd64;
  localparam logic [6:0] ACTIVE_MAX = 7'd64;
  localparam logic [5:0] QUOTA_MAX  = 6'd32;

  typedef enum logic [1:0] {
    CMD_LOAD_PROP = 2'd0,
    CMD_LOAD_RECV = 2'd1,
    CMD_RUN       = 2'd2,
    CMD_READ      = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    REG_QUOTA  = 1'b0,
    REG_ACTIVE = 1'b1
  } reg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ, ST_CLR, ST_BLD, ST_DEQ, ST_DEQ2, ST_DEQ3, ST_PROP,
    ST_P1, ST_P2, ST_P3, ST_S1, ST_S2, ST_S3, ST_C1, ST_C2, ST_D1, ST_D2,
    ST_SHORT
  } state_e;

  typedef struct packed {
    logic          vld;
    cmd_e          cmd;
    logic [IW-1:0] person;
    logic [IW-1:0] position;
    logic [IW-1:0] partner;
  } cmd_t;

  typedef struct packed {
    logic       vld;
    logic       matched;
    logic [5:0] match_count;
    logic       run_done;
    logic [6:0] short_count;
  } resp_t;

endpackage

### hdl/csm_ram.sv
module csm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/csm_engine.sv
module csm_engine import csm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic [5:0] quota_i,
  input  logic [6:0] active_i,
  output logic       idle_o,
  output resp_t      resp_o
);

  state_e state_q, state_d;
  logic [RKW-1:0]  n_q, n_d;
  logic [5:0]      q_q, q_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [IW-1:0]   s_q, s_d, r_q, r_d, wid_q, wid_d;
  logic [IW:0]     pos_q, pos_d;
  logic [5:0]      cur_q, cur_d, rh_q, rh_d;
  logic [QSW-1:0]  i_q, i_d, wslot_q, wslot_d;
  logic [RKW-1:0]  wrank_q, wrank_d;
  logic [QAW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [QAW:0]    fill_q, fill_d;
  logic [6:0]      short_q, short_d;
  logic            bld_vld_q, bld_vld_d, sh_vld_q, sh_vld_d, seen_q, seen_d;
  logic [IW-1:0]   bld_r_q, bld_i_q;

  // memory ports
  logic            pl_we, rr_we, iv_we, pm_we, mb_we, ph_we, rhd_we, hs_we, qu_we;
  logic [PAW-1:0]  pl_wa, pl_ra, rr_wa, rr_ra, iv_wa, iv_ra, pm_wa, pm_ra, mb_wa, mb_ra;
  logic [IW-1:0]   pl_wd, rr_wd, pl_rd, rr_rd, ph_wa, ph_ra, ph_wd, ph_rd;
  logic [IW-1:0]   rhd_wa, rhd_ra, rhd_wd, rhd_rd, hs_wd, hs_rd, qu_wd, qu_rd;
  logic [RKW-1:0]  iv_wd, iv_rd;
  logic            pm_wd, pm_rd, mb_wd, mb_rd;
  logic [HAW-1:0]  hs_wa, hs_ra;
  logic [QAW-1:0]  qu_wa, qu_ra;

  csm_ram #(.WIDTH(IW), .DEPTH(MAX_PEOPLE*MAX_PEOPLE)) u_plist (
    .clk_i, .we_i(pl_we), .waddr_i(pl_wa), .wdata_i(pl_wd), .raddr_i(pl_ra), .rdata_o(pl_rd));
  csm_ram #(.WIDTH(IW), .DEPTH(MAX_PEOPLE*MAX_PEOPLE)) u_rrank (
    .clk_i, .we_i(rr_we), .waddr_i(rr_wa), .wdata_i(rr_wd), .raddr_i(rr_ra), .rdata_o(rr_rd));
  csm_ram #(.WIDTH(RKW), .DEPTH(MAX_PEOPLE*MAX_PEOPLE)) u_inv (
    .clk_i, .we_i(iv_we), .waddr_i(iv_wa), .wdata_i(iv_wd), .raddr_i(iv_ra), .rdata_o(iv_rd));
  csm_ram #(.WIDTH(1), .DEPTH(MAX_PEOPLE*MAX_PEOPLE)) u_pmask (
    .clk_i, .we_i(pm_we), .waddr_i(pm_wa), .wdata_i(pm_wd), .raddr_i(pm_ra), .rdata_o(pm_rd));
  csm_ram #(.WIDTH(1), .DEPTH(MAX_PEOPLE*MAX_PEOPLE)) u_mbits (
    .clk_i, .we_i(mb_we), .waddr_i(mb_wa), .wdata_i(mb_wd), .raddr_i(mb_ra), .rdata_o(mb_rd));
  csm_ram #(.WIDTH(IW), .DEPTH(MAX_PEOPLE)) u_pheld (
    .clk_i, .we_i(ph_we), .waddr_i(ph_wa), .wdata_i(ph_wd), .raddr_i(ph_ra), .rdata_o(ph_rd));
  csm_ram #(.WIDTH(IW), .DEPTH(MAX_PEOPLE)) u_rheld (
    .clk_i, .we_i(rhd_we), .waddr_i(rhd_wa), .wdata_i(rhd_wd), .raddr_i(rhd_ra),
    .rdata_o(rhd_rd));
  csm_ram #(.WIDTH(IW), .DEPTH(MAX_PEOPLE*MAX_QUOTA)) u_slots (
    .clk_i, .we_i(hs_we), .waddr_i(hs_wa), .wdata_i(hs_wd), .raddr_i(hs_ra), .rdata_o(hs_rd));
  csm_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .we_i(qu_we), .waddr_i(qu_wa), .wdata_i(qu_wd), .raddr_i(qu_ra), .rdata_o(qu_rd));

  assign idle_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q; n_d = n_q; q_d = q_q; cnt_d = cnt_q; s_d = s_q; r_d = r_q;
    wid_d = wid_q; pos_d = pos_q; cur_d = cur_q; rh_d = rh_q; i_d = i_q;
    wslot_d = wslot_q; wrank_d = wrank_q; head_d = head_q; tail_d = tail_q;
    fill_d = fill_q; short_d = short_q; seen_d = seen_q;
    bld_vld_d = 1'b0; sh_vld_d = 1'b0;
    resp_o = '0;
    pl_we = 1'b0; pl_wa = {cmd_i.person, cmd_i.position}; pl_wd = cmd_i.partner;
    pl_ra = {s_q, pos_q[IW-1:0]};
    rr_we = 1'b0; rr_wa = {cmd_i.person, cmd_i.position}; rr_wd = cmd_i.partner;
    rr_ra = {cnt_q[PAW-1:IW], ~cnt_q[IW-1:0]};
    iv_we = 1'b0; iv_wa = cnt_q[PAW-1:0]; iv_wd = n_q; iv_ra = {r_q, hs_rd};
    pm_we = 1'b0; pm_wa = cnt_q[PAW-1:0]; pm_wd = 1'b0; pm_ra = {s_q, pl_rd};
    mb_we = 1'b0; mb_wa = cnt_q[PAW-1:0]; mb_wd = 1'b0; mb_ra = {cmd_i.person, cmd_i.partner};
    ph_we = 1'b0; ph_wa = cnt_q[IW-1:0]; ph_wd = '0; ph_ra = cmd_i.person;
    rhd_we = 1'b0; rhd_wa = cnt_q[IW-1:0]; rhd_wd = '0; rhd_ra = r_q;
    hs_we = 1'b0; hs_wa = {r_q, rh_q[QSW-1:0]}; hs_wd = s_q; hs_ra = {r_q, i_q};
    qu_we = 1'b0; qu_wa = cnt_q[QAW-1:0]; qu_wd = cnt_q[IW-1:0]; qu_ra = head_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_i.vld) begin
          case (cmd_i.cmd)
            CMD_LOAD_PROP: begin
              pl_we = 1'b1;
              resp_o.vld = 1'b1;
            end
            CMD_LOAD_RECV: begin
              rr_we = 1'b1;
              resp_o.vld = 1'b1;
            end
            CMD_RUN: begin
              n_d = (active_i > ACTIVE_MAX) ? ACTIVE_MAX : active_i;
              q_d = (quota_i == '0) ? 6'd1 : ((quota_i > QUOTA_MAX) ? QUOTA_MAX : quota_i);
              head_d = '0;
              tail_d = n_d;
              fill_d = {1'b0, n_d};
              cnt_d = '0;
              state_d = ST_CLR;
            end
            CMD_READ: state_d = ST_READ;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: begin
        resp_o.vld = 1'b1;
        resp_o.matched = seen_q & mb_rd;
        resp_o.match_count = seen_q ? ph_rd : '0;
        state_d = ST_IDLE;
      end
      // wipe the per-run tables and seed the queue with 0..n-1
      ST_CLR: begin
        iv_we = 1'b1; pm_we = 1'b1; mb_we = 1'b1; ph_we = 1'b1; rhd_we = 1'b1;
        qu_we = (cnt_q < {{(CNTW-RKW){1'b0}}, n_q});
        if (&cnt_q[PAW-1:0]) begin
          cnt_d = '0;
          state_d = ST_BLD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      // build rank lookup; walk positions high to low so the first one wins
      ST_BLD: begin
        bld_vld_d = !cnt_q[PAW] && ({1'b0, cnt_q[PAW-1:IW]} < n_q) &&
                    ({1'b0, ~cnt_q[IW-1:0]} < n_q);
        iv_we = bld_vld_q;
        iv_wa = {bld_r_q, rr_rd};
        iv_wd = {1'b0, bld_i_q};
        if (cnt_q[PAW]) begin
          state_d = ST_DEQ;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DEQ: begin
        if (fill_q == '0) begin
          cnt_d = '0;
          short_d = '0;
          state_d = ST_SHORT;
        end else begin
          head_d = head_q + 1'b1;
          fill_d = fill_q - 1'b1;
          state_d = ST_DEQ2;
        end
      end
      ST_DEQ2: begin
        s_d = qu_rd;
        ph_ra = qu_rd;
        state_d = ({1'b0, qu_rd} >= n_q) ? ST_DEQ : ST_DEQ3;
      end
      ST_DEQ3: begin
        cur_d = ph_rd;
        pos_d = '0;
        state_d = ST_PROP;
      end
      ST_PROP: begin
        if (pos_q < n_q && cur_q < q_q) begin
          pos_d = pos_q + 1'b1;
          state_d = ST_P1;
        end else begin
          ph_we = 1'b1; ph_wa = s_q; ph_wd = cur_q;
          state_d = ST_DEQ;
        end
      end
      ST_P1: begin
        r_d = pl_rd;
        state_d = ({1'b0, pl_rd} >= n_q) ? ST_PROP : ST_P2;
      end
      ST_P2: begin
        if (pm_rd) begin
          state_d = ST_PROP;
        end else begin
          pm_we = 1'b1; pm_wa = {s_q, r_q}; pm_wd = 1'b1;
          state_d = ST_P3;
        end
      end
      ST_P3: begin
        rh_d = rhd_rd;
        if (rhd_rd < q_q) begin
          hs_we = 1'b1; hs_wa = {r_q, rhd_rd[QSW-1:0]};
          rhd_we = 1'b1; rhd_wa = r_q; rhd_wd = rhd_rd + 1'b1;
          mb_we = 1'b1; mb_wa = {s_q, r_q}; mb_wd = 1'b1;
          cur_d = cur_q + 1'b1;
          state_d = ST_PROP;
        end else begin
          i_d = '0;
          state_d = ST_S1;
        end
      end
      ST_S1: state_d = ST_S2;
      ST_S2: state_d = ST_S3;
      // track worst holder, ties go to the higher slot
      ST_S3: begin
        if (i_q == '0 || iv_rd >= wrank_q) begin
          wrank_d = iv_rd;
          wslot_d = i_q;
          wid_d = hs_rd;
        end
        if (({1'b0, i_q} + 6'd1) < rh_q) begin
          i_d = i_q + 1'b1;
          state_d = ST_S1;
        end else begin
          state_d = ST_C1;
        end
      end
      ST_C1: begin
        iv_ra = {r_q, s_q};
        state_d = ST_C2;
      end
      ST_C2: begin
        ph_ra = wid_q;
        if (iv_rd < wrank_q) begin
          state_d = ST_D1;
        end else begin
          state_d = ST_PROP;
        end
      end
      // dump the worst holder
      ST_D1: begin
        if (ph_rd == q_q && fill_q < QUEUE_DEPTH[QAW:0]) begin
          qu_we = 1'b1; qu_wa = tail_q; qu_wd = wid_q;
          tail_d = tail_q + 1'b1;
          fill_d = fill_q + 1'b1;
        end
        ph_we = 1'b1; ph_wa = wid_q; ph_wd = (ph_rd == '0) ? '0 : ph_rd - 1'b1;
        mb_we = 1'b1; mb_wa = {wid_q, r_q}; mb_wd = 1'b0;
        hs_we = 1'b1; hs_wa = {r_q, wslot_q};
        cur_d = cur_q + 1'b1;
        state_d = ST_D2;
      end
      ST_D2: begin
        mb_we = 1'b1; mb_wa = {s_q, r_q}; mb_wd = 1'b1;
        state_d = ST_PROP;
      end
      ST_SHORT: begin
        ph_ra = cnt_q[IW-1:0];
        sh_vld_d = (cnt_q[RKW-1:0] < n_q);
        if (sh_vld_q && ph_rd < q_q) begin
          short_d = short_q + 1'b1;
        end
        if (cnt_q[RKW-1:0] == n_q) begin
          resp_o.vld = 1'b1;
          resp_o.run_done = 1'b1;
          resp_o.short_count = short_d;
          seen_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q <= 1'b0;
      bld_vld_q <= 1'b0;
      sh_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      seen_q <= seen_d;
      bld_vld_q <= bld_vld_d;
      sh_vld_q <= sh_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; q_q <= q_d; cnt_q <= cnt_d; s_q <= s_d; r_q <= r_d; wid_q <= wid_d;
    pos_q <= pos_d; cur_q <= cur_d; rh_q <= rh_d; i_q <= i_d; wslot_q <= wslot_d;
    wrank_q <= wrank_d; head_q <= head_d; tail_q <= tail_d; fill_q <= fill_d;
    short_q <= short_d;
    bld_r_q <= cnt_q[PAW-1:IW];
    bld_i_q <= ~cnt_q[IW-1:0];
  end

endmodule

### hdl/capacitated_stable_matcher.sv
// Capacitated stable matcher: many-to-many deferred acceptance with a quota
// on both sides.
// Input stream: s_axis_tuser carries the command (load proposer list entry,
// load receiver list entry, run, read); s_axis_tdata carries person,
// position and partner. Every input beat yields exactly one output beat.
// Output stream: tdata holds matched, match_count, short_count; tuser flags
// a finished run.
// A load returns a zero beat in the next cycle. A read returns through the
// registered memory read and the output register. A run first sweeps the
// 4096-entry pair tables (clear, then rank-table build), then walks the
// proposal loop through one sequencer sharing the table memories,
// examining each holder when a receiver is full, and ends with a pass
// that counts short proposers.
// The block takes no new beat while a command is in flight or while an
// unaccepted result waits; a stalled receiver holds the output register.
// Configuration (quota, active_count) is to be written through cfg_* while idle; the block does not enforce this.
// Reset sets quota to 20 and active_count to 64; reads before the first run
// return zero matches. List contents are undefined until loaded.
module capacitated_stable_matcher import csm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // person[5:0], position[11:6], partner[17:12]
  input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // matched[0], match_count[6:1], short_count[13:7]
  output logic        m_axis_tuser,   // run_done
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i
);

  logic [5:0] quota_q;
  logic [6:0] active_q;
  logic       out_vld_q;
  resp_t      out_q;
  resp_t      resp;
  cmd_t       cmd;
  logic       idle;

  assign s_axis_tready = idle && (!out_vld_q || m_axis_tready);
  assign cmd.vld      = s_axis_tvalid && s_axis_tready;
  assign cmd.cmd      = cmd_e'(s_axis_tuser);
  assign cmd.person   = s_axis_tdata[5:0];
  assign cmd.position = s_axis_tdata[11:6];
  assign cmd.partner  = s_axis_tdata[17:12];

  csm_engine u_engine (
    .clk_i, .rst_ni, .cmd_i(cmd), .quota_i(quota_q), .active_i(active_q),
    .idle_o(idle), .resp_o(resp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quota_q <= QUOTA_RST;
      active_q <= ACTIVE_RST;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (reg_e'(cfg_idx_i))
          REG_QUOTA:  quota_q <= cfg_data_i[5:0];
          REG_ACTIVE: active_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (resp.vld) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp.vld) begin
      out_q <= resp;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.short_count, out_q.match_count, out_q.matched};
  assign m_axis_tuser  = out_q.run_done;

endmodule
